// File: rtl/core/lbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lbs_pkg
// Types and constants for the linear blend skinning core.
// ----------------------------------------------------------------------------
package lbs_pkg;

	localparam int PaletteSize    = 64;
	localparam int ElemsPerMatrix = 12;
	localparam int PalDepth       = PaletteSize * ElemsPerMatrix;
	localparam int PalAw          = $clog2(PalDepth);
	localparam int BoneW          = $clog2(PaletteSize + 1);

	localparam logic CMD_LOAD      = 1'b0;
	localparam logic CMD_INFLUENCE = 1'b1;

	typedef struct packed {
		logic               cmd;
		logic [5:0]         matrix_index;
		logic [3:0]         element_index;
		logic signed [31:0] element_value;
		logic signed [31:0] vertex_x;
		logic signed [31:0] vertex_y;
		logic signed [31:0] vertex_z;
		logic [7:0]         bone_index;
		logic [15:0]        bone_weight;
		logic               last_influence;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] out_x;
		logic signed [31:0] out_y;
		logic signed [31:0] out_z;
		logic               unweighted;
	} out_item_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD,
		ST_MUL,
		ST_ACC,
		ST_WMUL,
		ST_SUM,
		ST_DIV_SETUP,
		ST_DIV,
		ST_DIV_DONE,
		ST_OUT
	} state_t;

endpackage

// File: rtl/core/linear_blend_vertex_skinning_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// linear_blend_vertex_skinning_top
// Linear blend skinning with a palette of Q16.16 affine matrices, one shared
// 32x32 multiplier and a bit-serial divider for the per-vertex average.
// ----------------------------------------------------------------------------
// Load and non-ending skipped influence: handled in ST_IDLE. Weighted influence,
// per axis: three read/multiply/add rounds, translation, weight product, sum.
// Ending influence: result after three serial divides when the total weight is
// nonzero; the divides are skipped when the total weight is zero.
// A held result does not stall input; the next result waits in ST_OUT for it.
// Reset clears sums, weight total, control and bones_in_use (64); not the palette.
module linear_blend_vertex_skinning_top (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  lbs_pkg::in_item_t in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output lbs_pkg::out_item_t out_data,
	input  logic              cfg_we,
	input  logic [6:0]        cfg_wdata
);
	import lbs_pkg::*;

	state_t state_q, state_d;

	logic [6:0] bones_q;
	in_item_t   item_q;
	logic [31:0] mem [PalDepth];
	logic [31:0] rd_s1;
	logic [PalAw-1:0] base_q;
	logic [1:0] axis_q;    // output axis / divide axis
	logic [1:0] col_q;     // matrix column 0..3
	logic signed [63:0] prod_q;
	logic signed [49:0] tacc_q;
	logic signed [63:0] sum_q [3];
	logic [31:0] wtot_q;
	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [6:0]  dcnt_q;
	logic        dneg_q;
	logic signed [31:0] res_q [3];
	logic        out_valid_q;
	out_item_t   out_q;

	logic accept;
	logic out_load;
	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_load = (state_q == ST_OUT) && !(out_valid_q && out_stall);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// bone limit and skip decision
	logic [BoneW-1:0] limit;
	logic hit;
	always_comb begin
		if (bones_q < 7'(PaletteSize)) limit = BoneW'(bones_q);
		else limit = BoneW'(PaletteSize);
		hit = (in_data.bone_weight != 16'd0) && ({1'b0, in_data.bone_index} < 9'(limit));
	end

	// saturation of the transformed coordinate
	logic signed [31:0] tsat;
	always_comb begin
		if (tacc_q > 50'sd2147483647) tsat = 32'sh7FFFFFFF;
		else if (tacc_q < -50'sd2147483648) tsat = 32'sh80000000;
		else tsat = tacc_q[31:0];
	end

	// shared multiplier operands
	logic signed [31:0] mul_a;
	logic signed [32:0] mul_b;
	logic signed [32:0] coord;
	always_comb begin
		case (col_q)
			2'd0: coord = 33'(item_q.vertex_x);
			2'd1: coord = 33'(item_q.vertex_y);
			default: coord = 33'(item_q.vertex_z);
		endcase
		if (state_q == ST_WMUL) begin
			mul_a = tsat;
			mul_b = $signed({17'd0, item_q.bone_weight});
		end else begin
			mul_a = $signed(rd_s1);
			mul_b = coord;
		end
	end

	// saturating add of the weighted product
	logic signed [64:0] sadd;
	logic signed [63:0] ssat;
	always_comb begin
		sadd = 65'(sum_q[axis_q]) + 65'(prod_q);
		if (sadd[64] != sadd[63]) ssat = sadd[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		else ssat = sadd[63:0];
	end

	// divider step
	logic [64:0] trial;
	logic [63:0] dmag;
	logic [63:0] rem_sh;
	always_comb begin
		dmag   = sum_q[axis_q][63] ? 64'(-sum_q[axis_q]) : 64'(sum_q[axis_q]);
		rem_sh = {rem_q[62:0], quo_q[63]};
		trial  = {1'b0, rem_sh} - {33'd0, wtot_q};
	end

	logic [31:0] div_res;
	always_comb begin
		if (dneg_q) begin
			if (quo_q >= 64'h80000000) div_res = 32'h80000000;
			else div_res = 32'(64'd0 - quo_q);
		end else begin
			if (quo_q > 64'h7FFFFFFF) div_res = 32'h7FFFFFFF;
			else div_res = quo_q[31:0];
		end
	end

	logic last_axis, last_col;
	assign last_axis = (axis_q == 2'd2);
	assign last_col  = (col_q == 2'd3);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && in_data.cmd == CMD_INFLUENCE) begin
					if (hit) state_d = ST_RD;
					else if (in_data.last_influence) state_d = ST_SUM;
				end
			end
			ST_RD:   state_d = last_col ? ST_ACC : ST_MUL;
			ST_MUL:  state_d = ST_ACC;
			ST_ACC:  state_d = last_col ? ST_WMUL : ST_RD;
			ST_WMUL: state_d = ST_SUM;
			ST_SUM: begin
				if (col_q == 2'd1) state_d = last_axis ?
					(item_q.last_influence ? ST_DIV_SETUP : ST_IDLE) : ST_RD;
				else if (col_q == 2'd2) state_d = ST_DIV_SETUP;
			end
			ST_DIV_SETUP: state_d = (wtot_q == 32'd0) ? ST_OUT : ST_DIV;
			ST_DIV:  state_d = (dcnt_q == 7'd63) ? ST_DIV_DONE : ST_DIV;
			ST_DIV_DONE: state_d = last_axis ? ST_OUT : ST_DIV_SETUP;
			ST_OUT:  state_d = out_load ? ST_IDLE : ST_OUT;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	// palette memory
	logic [PalAw-1:0] rd_addr;
	assign rd_addr = base_q + PalAw'({col_q, 1'b0}) + PalAw'(col_q) + PalAw'(axis_q);
	always_ff @(posedge clk) begin
		if (accept && in_data.cmd == CMD_LOAD && {1'b0, in_data.matrix_index} < 7'(PaletteSize)
			&& in_data.element_index < 4'(ElemsPerMatrix))
			mem[PalAw'(in_data.matrix_index) * PalAw'(ElemsPerMatrix)
				+ PalAw'(in_data.element_index)] <= in_data.element_value;
		rd_s1 <= mem[rd_addr];
	end

	// config register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) bones_q <= 7'd64;
		else if (cfg_we) bones_q <= cfg_wdata;
	end

	// datapath and sequencing counters
	// col_q in ST_SUM: 1 = add the weighted product; 2 marks an ending skipped item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
			wtot_q <= '0; axis_q <= '0; col_q <= '0; out_valid_q <= 1'b0;
			dcnt_q <= '0;
		end else begin
			if (out_load) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						item_q <= in_data;
						base_q <= PalAw'(in_data.bone_index) * PalAw'(ElemsPerMatrix);
						axis_q <= 2'd0;
						col_q  <= hit ? 2'd0 : 2'd2;
						tacc_q <= '0;
						if (accept && in_data.cmd == CMD_INFLUENCE && hit) begin
							if (wtot_q > 32'hFFFFFFFF - {16'd0, in_data.bone_weight})
								wtot_q <= 32'hFFFFFFFF;
							else
								wtot_q <= wtot_q + {16'd0, in_data.bone_weight};
						end
					end
				end
				ST_RD: ;
				ST_MUL: prod_q <= 64'(mul_a) * 64'(mul_b);
				ST_ACC: begin
					if (last_col) tacc_q <= tacc_q + 50'(signed'(rd_s1));
					else tacc_q <= tacc_q + 50'(prod_q >>> 16);
					if (!last_col) col_q <= col_q + 2'd1;
				end
				ST_WMUL: begin
					prod_q <= 64'(mul_a) * 64'(mul_b);
					col_q  <= 2'd1;
				end
				ST_SUM: begin
					if (col_q == 2'd1) begin
						sum_q[axis_q] <= ssat;
						tacc_q <= '0;
						if (!last_axis) begin
							axis_q <= axis_q + 2'd1;
							col_q  <= 2'd0;
						end else begin
							axis_q <= 2'd0;
						end
					end else begin
						axis_q <= 2'd0;
					end
				end
				ST_DIV_SETUP: begin
					rem_q  <= '0;
					quo_q  <= dmag;
					dneg_q <= sum_q[axis_q][63];
					dcnt_q <= '0;
				end
				ST_DIV: begin
					if (!trial[64]) begin
						rem_q <= trial[63:0];
						quo_q <= {quo_q[62:0], 1'b1};
					end else begin
						rem_q <= rem_sh;
						quo_q <= {quo_q[62:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 7'd1;
				end
				ST_DIV_DONE: begin
					res_q[axis_q] <= div_res;
					if (!last_axis) axis_q <= axis_q + 2'd1;
				end
				ST_OUT: begin
					if (out_load) begin
						if (wtot_q == 32'd0) begin
							out_q <= {item_q.vertex_x, item_q.vertex_y, item_q.vertex_z, 1'b1};
						end else begin
							out_q <= {res_q[0], res_q[1], res_q[2], 1'b0};
						end
						sum_q[0] <= '0; sum_q[1] <= '0; sum_q[2] <= '0;
						wtot_q <= '0;
						axis_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !accept) else $error("accept while busy");
	a_out_after_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_OUT) else $error("stray result");
	a_clear_on_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_load) |=> wtot_q == 32'd0) else $error("total not cleared");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> dcnt_q < 7'd64) else $error("divide overrun");
`endif

endmodule
